@@ hw/rtl/wsht_pkg.sv @@
// Shared types and constants for the window stack hit test block.
// Holds the command and result transaction structs and the operation codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsht_pkg;

    localparam int WIN_W   = 4;
    localparam int COORD_W = 12;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CLICK = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [WIN_W-1:0]   window_index;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] bottom_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic [WIN_W-1:0] hit_window;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/wsht_rect_mem.sv @@
// Rectangle store for the window stack hit test block.
// One write port and one registered read port; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wsht_rect_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/window_stack_hit_test.sv @@
// Top level of the window stack hit test block.
// Depends on wsht_pkg for the transaction types and on wsht_rect_mem.
//
// A command transaction is taken at a rising edge where start is high and busy
// is low. A load writes one window rectangle and brings that window to the top
// of the z-order stack; it produces no result. A click walks the stack from
// the top, one entry per cycle through a single registered rectangle read and
// one containment comparator, then rotates the hit window to the top.
// Each click produces exactly one result, shown on o_result for one cycle with
// o_result_valid high; the receiver cannot stall it.
// A click keeps busy high while it walks the stack. The result strobe comes
// in the first cycle with busy low again. A load of a new window goes straight
// to the rotation; reloading a window already on the stack walks the stack
// entry by entry like a click, comparing window indices instead of reading
// rectangles, and then rotates it.
// Reset empties the stack and clears the loaded flags; rectangle contents are
// not cleared, since only loaded windows are ever read.
`timescale 1ns / 1ps
`default_nettype none

module window_stack_hit_test #(
    parameter int MAX_WINDOWS = 16,
    parameter int COORD_BITS  = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire wsht_pkg::t_cmd   i_cmd,
    output logic                  busy,
    output logic                  o_result_valid,
    output wsht_pkg::t_result     o_result
);

    localparam int NW   = (MAX_WINDOWS < (1 << wsht_pkg::WIN_W)) ?
                          MAX_WINDOWS : (1 << wsht_pkg::WIN_W);
    localparam int CW   = (COORD_BITS < wsht_pkg::COORD_W) ? COORD_BITS : wsht_pkg::COORD_W;
    localparam int PW   = $clog2(NW);
    localparam int CNTW = $clog2(NW + 1);
    localparam int WW   = wsht_pkg::WIN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;

    logic [1:0]      r_state, n_state;
    logic            r_op, n_op;
    logic [WW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_px, n_px;
    logic [CW-1:0]   r_py, n_py;
    logic [CNTW-1:0] r_pos, n_pos;
    logic            r_rd_vld, n_rd_vld;
    logic [PW-1:0]   r_rd_pos, n_rd_pos;
    logic [WW-1:0]   r_rd_win, n_rd_win;
    logic [PW-1:0]   r_mv_pos, n_mv_pos;
    logic [WW-1:0]   r_mv_win, n_mv_win;
    logic            r_mv_new, n_mv_new;
    logic [CNTW-1:0] r_count, n_count;
    logic [NW-1:0]   r_flags, n_flags;
    logic            r_out_vld, n_out_vld;
    wsht_pkg::t_result r_out, n_out;
    logic [WW-1:0]   r_order [0:NW-1];

    logic            accept;
    logic            idx_ok;
    logic            issue;
    logic [PW-1:0]   rd_sel;
    logic [WW-1:0]   rd_win;
    logic            contains;
    logic            match;
    logic            mem_we;
    logic            mem_re;
    logic [4*CW-1:0] mem_wdata;
    logic [4*CW-1:0] mem_rdata;
    logic [CW-1:0]   q_lx, q_by, q_rx, q_ty;

    assign accept = start && !busy;
    assign idx_ok = {1'b0, i_cmd.window_index} < (WW + 1)'(NW);
    assign mem_we = accept && (i_cmd.operation == wsht_pkg::OP_LOAD) && idx_ok;
    assign mem_wdata = {i_cmd.left_x[CW-1:0], i_cmd.bottom_y[CW-1:0],
                        i_cmd.right_x[CW-1:0], i_cmd.top_y[CW-1:0]};

    assign issue  = (r_state == S_WALK) && (r_pos < r_count);
    assign rd_sel = issue ? r_pos[PW-1:0] : '0;
    assign rd_win = r_order[rd_sel];
    assign mem_re = issue && (r_op == wsht_pkg::OP_CLICK);

    wsht_rect_mem #(
        .DEPTH (NW),
        .AW    (PW),
        .DW    (4 * CW)
    ) u_rect_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_cmd.window_index[PW-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (rd_win[PW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign {q_lx, q_by, q_rx, q_ty} = mem_rdata;
    assign contains = (r_px >= q_lx) && (r_px <= q_rx) && (r_py >= q_by) && (r_py <= q_ty);
    assign match = r_rd_vld && ((r_op == wsht_pkg::OP_CLICK) ? contains : (r_rd_win == r_idx));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_px      = r_px;
        n_py      = r_py;
        n_pos     = r_pos;
        n_rd_vld  = 1'b0;
        n_rd_pos  = r_rd_pos;
        n_rd_win  = r_rd_win;
        n_mv_pos  = r_mv_pos;
        n_mv_win  = r_mv_win;
        n_mv_new  = r_mv_new;
        n_count   = r_count;
        n_flags   = r_flags;
        n_out_vld = 1'b0;
        n_out     = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_cmd.operation;
                    n_idx = i_cmd.window_index;
                    n_px  = i_cmd.point_x[CW-1:0];
                    n_py  = i_cmd.point_y[CW-1:0];
                    n_pos = '0;
                    if (i_cmd.operation == wsht_pkg::OP_CLICK) begin
                        n_state = S_WALK;
                    end else if (idx_ok) begin
                        if (r_flags[i_cmd.window_index[PW-1:0]]) begin
                            n_state = S_WALK;
                        end else begin
                            n_state  = S_MOVE;
                            n_mv_pos = r_count[PW-1:0];
                            n_mv_win = i_cmd.window_index;
                            n_mv_new = 1'b1;
                        end
                    end
                end
            end
            S_WALK: begin
                if (match) begin
                    n_state  = S_MOVE;
                    n_mv_pos = r_rd_pos;
                    n_mv_win = r_rd_win;
                    n_mv_new = 1'b0;
                end else if (!r_rd_vld && !issue) begin
                    n_state   = S_IDLE;
                    n_out_vld = (r_op == wsht_pkg::OP_CLICK);
                    n_out     = '0;
                end else begin
                    n_rd_vld = issue;
                    n_rd_pos = r_pos[PW-1:0];
                    n_rd_win = rd_win;
                    if (issue) begin
                        n_pos = r_pos + CNTW'(1);
                    end
                end
            end
            S_MOVE: begin
                n_state = S_IDLE;
                if (r_mv_new) begin
                    n_count           = r_count + CNTW'(1);
                    n_flags[r_mv_win[PW-1:0]] = 1'b1;
                end
                n_out_vld        = (r_op == wsht_pkg::OP_CLICK);
                n_out.hit        = 1'b1;
                n_out.hit_window = r_mv_win;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_flags   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_count   <= n_count;
            r_flags   <= n_flags;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_px     <= n_px;
        r_py     <= n_py;
        r_pos    <= n_pos;
        r_rd_pos <= n_rd_pos;
        r_rd_win <= n_rd_win;
        r_mv_pos <= n_mv_pos;
        r_mv_win <= n_mv_win;
        r_mv_new <= n_mv_new;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MOVE) begin
            r_order[0] <= r_mv_win;
            for (int j = 1; j < NW; j++) begin
                if (PW'(j) <= r_mv_pos) begin
                    r_order[j] <= r_order[j-1];
                end
            end
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    a_count_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_flags) == int'(r_count))
        else $error("stack count differs from the number of loaded windows");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($past(r_state) == S_WALK || $past(r_state) == S_MOVE))
        else $error("result strobe without a finished click");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_state == S_IDLE))
        else $error("result shown while still busy");

    a_move_in_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && !r_mv_new) |-> (CNTW'(r_mv_pos) < r_count))
        else $error("rotation position beyond the stack");

    a_new_window_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && r_mv_new) |-> (r_count < CNTW'(NW)))
        else $error("push onto a full stack");

endmodule

`default_nettype wire

@@ tb/window_stack_hit_test_checker.sv @@
// Checker for the window stack hit test block: watches both channels,
// keeps its own z-order stack and rectangle store, and compares clicks.
// Depends on wsht_pkg for the transaction types and operation codes.
`timescale 1ns / 1ps

module window_stack_hit_test_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wsht_pkg::t_cmd         i_cmd,
    input  wire logic              i_result_valid,
    input  wsht_pkg::t_result      i_result,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_clicks,
    output int                     o_hits
);

    import wsht_pkg::*;

    localparam int NUM_WINDOWS = 16;

    typedef struct packed {
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ty;
    } t_rect;

    t_rect            rects[NUM_WINDOWS];
    logic [WIN_W-1:0] z_order[NUM_WINDOWS];
    int               z_count = 0;
    logic             loaded[NUM_WINDOWS];
    t_result          expected_clicks[$];
    int               fail_n = 0;
    int               click_n = 0;
    int               hit_n = 0;

    task automatic raise_to_top(input int pos);
        logic [WIN_W-1:0] w;
        w = z_order[pos];
        for (int i = pos; i > 0; i--) z_order[i] = z_order[i-1];
        z_order[0] = w;
    endtask

    task automatic apply_load(input t_cmd c);
        int idx;
        idx = int'(c.window_index);
        if (idx >= NUM_WINDOWS) return;
        rects[idx].lx = c.left_x;
        rects[idx].by = c.bottom_y;
        rects[idx].rx = c.right_x;
        rects[idx].ty = c.top_y;
        if (loaded[idx]) begin
            for (int i = 0; i < z_count; i++) begin
                if (z_order[i] == idx) begin
                    raise_to_top(i);
                    return;
                end
            end
            return;
        end
        if (z_count >= NUM_WINDOWS) return;
        z_order[z_count] = WIN_W'(idx);
        raise_to_top(z_count);
        z_count++;
        loaded[idx] = 1'b1;
    endtask

    task automatic resolve_click(input t_cmd c, output t_result r);
        logic [WIN_W-1:0] w;
        r = '0;
        for (int i = 0; i < z_count; i++) begin
            w = z_order[i];
            if (c.point_x >= rects[w].lx && c.point_x <= rects[w].rx &&
                c.point_y >= rects[w].by && c.point_y <= rects[w].ty) begin
                raise_to_top(i);
                r.hit        = 1'b1;
                r.hit_window = w;
                return;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            z_count = 0;
            for (int i = 0; i < NUM_WINDOWS; i++) loaded[i] = 1'b0;
            expected_clicks.delete();
        end else begin
            if (i_result_valid === 1'b1) begin
                if (expected_clicks.size() == 0) begin
                    fail_n++;
                    $display("%0t: result with no click waiting: expected none, ", $time,
                             "actual hit=%0b window=%0d", i_result.hit, i_result.hit_window);
                end else begin
                    want = expected_clicks.pop_front();
                    click_n++;
                    if (i_result.hit === 1'b1) hit_n++;
                    if (i_result.hit !== want.hit ||
                        i_result.hit_window !== want.hit_window) begin
                        fail_n++;
                        $display("%0t: click mismatch: expected hit=%0b window=%0d, ",
                                 $time, want.hit, want.hit_window,
                                 "actual hit=%0b window=%0d",
                                 i_result.hit, i_result.hit_window);
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                if (i_cmd.operation == OP_CLICK) begin
                    resolve_click(i_cmd, predicted);
                    expected_clicks.push_back(predicted);
                end else begin
                    apply_load(i_cmd);
                end
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= expected_clicks.size();
        o_clicks     <= click_n;
        o_hits       <= hit_n;
    end

endmodule

@@ tb/testbench.sv @@
// Top of the window stack hit test testbench: clock, reset, command stimulus
// and the final verdict. Depends on wsht_pkg, the block and the checker module.
`timescale 1ns / 1ps

module testbench;

    import wsht_pkg::*;

    localparam int NUM_WINDOWS = 16;
    localparam int MAX_COORD   = 4095;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    cmd = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    int fail_count;
    int pending;
    int clicks_seen;
    int hits_seen;

    int  loads_sent = 0;
    int  clicks_sent = 0;
    bit  no_idle = 1'b0;
    bit  aim_known[NUM_WINDOWS];
    int  aim_lx[NUM_WINDOWS];
    int  aim_by[NUM_WINDOWS];
    int  aim_rx[NUM_WINDOWS];
    int  aim_ty[NUM_WINDOWS];

    always #4 i_clk = ~i_clk;

    window_stack_hit_test DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    window_stack_hit_test_checker u_hit_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (cmd),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_clicks       (clicks_seen),
        .o_hits         (hits_seen)
    );

    function automatic t_cmd make_load(input int idx, input int lx, input int by,
                                       input int rx, input int ty);
        t_cmd c;
        c.operation    = OP_LOAD;
        c.window_index = idx[WIN_W-1:0];
        c.left_x       = lx[COORD_W-1:0];
        c.bottom_y     = by[COORD_W-1:0];
        c.right_x      = rx[COORD_W-1:0];
        c.top_y        = ty[COORD_W-1:0];
        c.point_x      = COORD_W'($urandom_range(0, MAX_COORD));
        c.point_y      = COORD_W'($urandom_range(0, MAX_COORD));
        return c;
    endfunction

    function automatic t_cmd make_click(input int px, input int py);
        t_cmd c;
        c.operation    = OP_CLICK;
        c.window_index = WIN_W'($urandom_range(0, NUM_WINDOWS - 1));
        c.left_x       = COORD_W'($urandom_range(0, MAX_COORD));
        c.bottom_y     = COORD_W'($urandom_range(0, MAX_COORD));
        c.right_x      = COORD_W'($urandom_range(0, MAX_COORD));
        c.top_y        = COORD_W'($urandom_range(0, MAX_COORD));
        c.point_x      = px[COORD_W-1:0];
        c.point_y      = py[COORD_W-1:0];
        return c;
    endfunction

    task automatic send(input t_cmd c);
        int gap;
        int idx;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (c.operation == OP_LOAD) begin
            idx            = int'(c.window_index);
            aim_known[idx] = 1'b1;
            aim_lx[idx]    = int'(c.left_x);
            aim_by[idx]    = int'(c.bottom_y);
            aim_rx[idx]    = int'(c.right_x);
            aim_ty[idx]    = int'(c.top_y);
            loads_sent++;
        end else begin
            clicks_sent++;
        end
    endtask

    task automatic pick_span(input int mode, output int lo, output int hi);
        int span;
        span = (mode < 6) ? 255 : (mode < 9) ? 1023 : MAX_COORD;
        lo   = $urandom_range(0, MAX_COORD);
        hi   = lo + $urandom_range(0, span);
        if (hi > MAX_COORD) hi = MAX_COORD;
    endtask

    task automatic send_random_load();
        int mode;
        int lx, by, rx, ty;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            lx = $urandom_range(0, MAX_COORD);
            by = $urandom_range(0, MAX_COORD);
            rx = $urandom_range(0, MAX_COORD);
            ty = $urandom_range(0, MAX_COORD);
        end else begin
            pick_span(mode, lx, rx);
            pick_span($urandom_range(1, 9), by, ty);
        end
        send(make_load($urandom_range(0, NUM_WINDOWS - 1), lx, by, rx, ty));
    endtask

    task automatic send_random_click();
        int targets[$];
        int w;
        int px, py;
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            if (aim_known[i] && aim_lx[i] <= aim_rx[i] && aim_by[i] <= aim_ty[i])
                targets.push_back(i);
        end
        if (targets.size() > 0 && $urandom_range(0, 9) < 7) begin
            w  = targets[$urandom_range(0, targets.size() - 1)];
            px = $urandom_range(aim_lx[w], aim_rx[w]);
            py = $urandom_range(aim_by[w], aim_ty[w]);
        end else begin
            px = $urandom_range(0, MAX_COORD);
            py = $urandom_range(0, MAX_COORD);
        end
        send(make_click(px, py));
    endtask

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int n_known;
        for (int i = 0; i < NUM_WINDOWS; i++) aim_known[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty stack, screen corners, empty rectangles,
        // reloads that move a window to the front, inclusive edges.
        send(make_click(0, 0));
        send(make_click(MAX_COORD, MAX_COORD));
        send(make_load(0, 0, 0, MAX_COORD, MAX_COORD));
        send(make_load(15, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
        send(make_click(MAX_COORD, MAX_COORD));
        send(make_click(0, 0));
        send(make_click(MAX_COORD, MAX_COORD));
        send(make_load(3, 100, 0, 50, MAX_COORD));
        send(make_load(4, 0, 200, MAX_COORD, 100));
        send(make_click(75, 10));
        send(make_click(10, 150));
        send(make_load(7, 0, 0, 0, 0));
        send(make_click(0, 0));
        send(make_load(15, 2048, 2048, MAX_COORD, MAX_COORD));
        send(make_click(3000, 3000));
        send(make_click(1000, 1000));
        send(make_load(3, 10, 10, 20, 20));
        send(make_click(15, 15));
        send(make_click(20, 20));
        send(make_click(21, 21));
        send(make_click(2048, 2047));
        send(make_load(10, 1365, 2730, 2730, 1365));
        send(make_click(2047, 2048));

        for (int n = 0; n < 530; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            n_known = 0;
            for (int i = 0; i < NUM_WINDOWS; i++) n_known += int'(aim_known[i]);
            if ($urandom_range(0, 9) < ((n_known < 4) ? 7 : 3))
                send_random_load();
            else
                send_random_click();
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d loads and %0d clicks; ", loads_sent, clicks_sent,
                 "%0d click results checked, %0d of them hits.", clicks_seen, hits_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
